@@ sv/stereo_linear_resampler_top_assert.svh @@
// Assertion helpers for the resampler top level.
`ifndef STEREO_LINEAR_RESAMPLER_TOP_ASSERT_SVH
`define STEREO_LINEAR_RESAMPLER_TOP_ASSERT_SVH

// Same-cycle implication, disabled while in reset.
`define SLR_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("resampler check failed");

// Next-cycle implication, disabled while in reset.
`define SLR_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("resampler check failed");

`endif

@@ sv/slr_pkg.sv @@
package slr_pkg;

    localparam int MAX_RUN    = 16;
    localparam int CNT_W      = $clog2(MAX_RUN + 1);
    localparam int SAMPLE_W   = 16;
    localparam int PHASE_W    = 19;
    localparam int FRAC_W     = 15;

    localparam logic [PHASE_W:0]   ONE_Q16    = 20'h10000;
    localparam logic [PHASE_W-1:0] STEP_RESET = 19'h10000;

    // configuration register indexes
    localparam logic REG_STEP   = 1'b0;
    localparam logic REG_BYPASS = 1'b1;

    // control that travels with a beat through the datapath
    typedef struct packed {
        logic valid;
        logic last;
    } beat_ctl_t;

endpackage

@@ sv/slr_lane.sv @@
module slr_lane
    import slr_pkg::*;
(
    input  logic                       clk,
    input  logic                       en,
    input  logic signed [SAMPLE_W-1:0] prev,
    input  logic signed [SAMPLE_W-1:0] next,
    input  logic        [FRAC_W-1:0]   frac,
    output logic signed [SAMPLE_W-1:0] result
);

    logic signed [SAMPLE_W:0]   diff;
    logic signed [2*SAMPLE_W:0] prod;
    logic signed [2*SAMPLE_W:0] prod_reg;
    logic signed [SAMPLE_W-1:0] prev_reg;

    assign diff = {next[SAMPLE_W-1], next} - {prev[SAMPLE_W-1], prev};
    assign prod = diff * $signed({1'b0, frac});

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= prod;
            prev_reg <= prev;
        end
    end

    // floor division by 2^15, wrap to 16 bits
    assign result = prev_reg + prod_reg[FRAC_W +: SAMPLE_W];

endmodule

@@ sv/slr_merge.sv @@
module slr_merge
    import slr_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  beat_ctl_t                  ctl,
    input  logic signed [SAMPLE_W-1:0] left_res,
    input  logic signed [SAMPLE_W-1:0] right_res,
    input  logic                       m_tready,
    output logic                       m_tvalid,
    output logic [2*SAMPLE_W-1:0]      m_tdata,  // left_out [15:0], right_out [31:16]
    output logic                       m_tlast,  // run_last
    output logic                       adv
);

    logic                  valid_reg;
    logic                  last_reg;
    logic [2*SAMPLE_W-1:0] data_reg;

    assign adv = !valid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (adv)
            valid_reg <= ctl.valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            data_reg <= {right_res, left_res};
            last_reg <= ctl.last;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;
    assign m_tlast  = last_reg;

endmodule

@@ sv/stereo_linear_resampler_top.sv @@
// Path: a started run passes the run, lane product and output registers to m_tvalid.
// Throughput: one output beat per cycle while not stalled by m_tready; a frame causes
// up to 16 beats; s_tready is low until the single shared output sequencer is done.
// Outside bypass, a frame with no output (first, phase at or above 1.0) starts no run.
// Reset: async active low; clears held frame, phase, pipeline; step = 1.0, bypass on.
module stereo_linear_resampler_top
    import slr_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [2*SAMPLE_W-1:0] s_tdata,   // left_in [15:0], right_in [31:16]
    input  logic                  s_tlast,   // block_end, carries no meaning here
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [2*SAMPLE_W-1:0] m_tdata,   // left_out [15:0], right_out [31:16]
    output logic                  m_tlast,   // run_last
    input  logic                  cfg_we,
    input  logic                  cfg_addr,
    input  logic [PHASE_W-1:0]    cfg_wdata
);

    logic [PHASE_W-1:0]   step_reg;
    logic                 bypass_reg;
    logic [PHASE_W-1:0]   phase_acc_reg;
    logic                 held_valid_reg;
    logic                 busy_reg;
    logic                 byp_run_reg;
    logic [15:0]          phase_reg;
    logic [CNT_W-1:0]     cnt_reg;
    beat_ctl_t            s1_ctl_reg;

    logic [SAMPLE_W-1:0]  held_l_reg, held_r_reg;
    logic [SAMPLE_W-1:0]  prev_l_reg, prev_r_reg, next_l_reg, next_r_reg;

    logic                 in_fire;
    logic                 adv;
    logic                 issue;
    logic                 issue_last;
    logic [PHASE_W:0]     phase_sum;
    logic                 sum_wrap;
    logic                 acc_wrap;
    logic                 start_run;
    beat_ctl_t            issue_ctl;
    logic signed [SAMPLE_W-1:0] left_res, right_res;

    assign s_tready  = !busy_reg;
    assign in_fire   = s_tvalid && s_tready && !s_tlast || s_tvalid && s_tready && s_tlast;
    assign acc_wrap  = phase_acc_reg[PHASE_W-1:16] != '0;
    assign start_run = in_fire && (bypass_reg || (held_valid_reg && !acc_wrap));

    assign issue      = busy_reg && adv;
    assign phase_sum  = {{(PHASE_W-15){1'b0}}, phase_reg} + {1'b0, step_reg};
    assign sum_wrap   = phase_sum >= ONE_Q16;
    assign issue_last = byp_run_reg || sum_wrap || (cnt_reg == CNT_W'(MAX_RUN - 1));

    assign issue_ctl.valid = issue;
    assign issue_ctl.last  = issue_last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg       <= STEP_RESET;
            bypass_reg     <= 1'b1;
            phase_acc_reg  <= '0;
            held_valid_reg <= 1'b0;
            busy_reg       <= 1'b0;
            byp_run_reg    <= 1'b0;
            phase_reg      <= '0;
            cnt_reg        <= '0;
            s1_ctl_reg     <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_addr)
                    REG_STEP:   step_reg   <= cfg_wdata;
                    REG_BYPASS: bypass_reg <= cfg_wdata[0];
                    default:    ;
                endcase
            end

            if (adv)
                s1_ctl_reg <= issue_ctl;

            if (in_fire && !bypass_reg)
            begin
                held_valid_reg <= 1'b1;
                if (held_valid_reg && acc_wrap)
                    phase_acc_reg <= PHASE_W'({1'b0, phase_acc_reg} - ONE_Q16);
            end

            if (start_run)
            begin
                busy_reg    <= 1'b1;
                byp_run_reg <= bypass_reg;
                phase_reg   <= bypass_reg ? '0 : phase_acc_reg[15:0];
                cnt_reg     <= '0;
            end
            else if (issue)
            begin
                if (issue_last)
                begin
                    busy_reg <= 1'b0;
                    if (!byp_run_reg)
                        phase_acc_reg <= sum_wrap ? PHASE_W'(phase_sum - ONE_Q16) : '0;
                end
                else
                begin
                    phase_reg <= phase_sum[15:0];
                    cnt_reg   <= cnt_reg + 1'b1;
                end
            end
        end
    end

    // frame payload; bypass runs interpolate between two copies of the input
    always_ff @(posedge clk)
    begin
        if (in_fire && !bypass_reg)
        begin
            held_l_reg <= s_tdata[SAMPLE_W-1:0];
            held_r_reg <= s_tdata[2*SAMPLE_W-1:SAMPLE_W];
        end
        if (start_run)
        begin
            next_l_reg <= s_tdata[SAMPLE_W-1:0];
            next_r_reg <= s_tdata[2*SAMPLE_W-1:SAMPLE_W];
            prev_l_reg <= bypass_reg ? s_tdata[SAMPLE_W-1:0] : held_l_reg;
            prev_r_reg <= bypass_reg ? s_tdata[2*SAMPLE_W-1:SAMPLE_W] : held_r_reg;
        end
    end

    slr_lane u_lane_left (
        .clk    (clk),
        .en     (adv),
        .prev   (prev_l_reg),
        .next   (next_l_reg),
        .frac   (phase_reg[FRAC_W:1]),
        .result (left_res)
    );

    slr_lane u_lane_right (
        .clk    (clk),
        .en     (adv),
        .prev   (prev_r_reg),
        .next   (next_r_reg),
        .frac   (phase_reg[FRAC_W:1]),
        .result (right_res)
    );

    slr_merge u_merge (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (s1_ctl_reg),
        .left_res  (left_res),
        .right_res (right_res),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .adv       (adv)
    );

`include "stereo_linear_resampler_top_assert.svh"

    `SLR_ASSERT_SAME(a_cnt_in_range, busy_reg, cnt_reg < CNT_W'(MAX_RUN))
    `SLR_ASSERT_SAME(a_bypass_single, issue && byp_run_reg, issue_last)
    `SLR_ASSERT_NEXT(a_bypass_starts, in_fire && bypass_reg, busy_reg && byp_run_reg)

endmodule
